@@ rtl/core/nrd_pkg.sv @@
// Package: shared types and constants for the NFC reader response deframer.
`default_nettype none
package nrd_pkg;

  localparam int BUFFER_BYTES = 300;
  localparam int POS_W        = $clog2(BUFFER_BYTES + 1);

  localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(8);
  localparam logic [POS_W-1:0] BUFFER_LAST  = POS_W'(BUFFER_BYTES);

  localparam logic [7:0] START_ZERO = 8'h00;
  localparam logic [7:0] START_FF   = 8'hFF;
  localparam logic [7:0] TFI_VALUE  = 8'hD5;
  localparam logic [7:0] LEN_MIN    = 8'd2;
  localparam logic [7:0] LIMIT_RST  = 8'd255;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [2:0] FAULT_NONE  = 3'd0;
  localparam logic [2:0] FAULT_SHORT = 3'd1;
  localparam logic [2:0] FAULT_START = 3'd2;
  localparam logic [2:0] FAULT_TFI   = 3'd3;
  localparam logic [2:0] FAULT_LEN   = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_read;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_count;
    logic [2:0] fault;
    logic       last;
  } out_t;

  // Results produced by one accepted byte, in order.
  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } push_t;

endpackage
`default_nettype wire

@@ rtl/core/nrd_parser.sv @@
// Frame parser: header checks, payload gating and end-of-read result.
`default_nettype none
module nrd_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire nrd_pkg::in_t  item,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_data,
  output nrd_pkg::push_t     push
);
  import nrd_pkg::*;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       frame_length, frame_length_next;
  logic [7:0]       delivered_count, delivered_count_next;
  logic [2:0]       fault_seen, fault_seen_next;
  logic [7:0]       payload_limit;

  logic       stored;
  logic       emit;
  logic [2:0] code;
  logic [7:0] cap;
  logic [2:0] final_fault;
  out_t       data_res;
  out_t       final_res;

  always_comb begin
    stored = byte_position < BUFFER_LAST;
    code   = FAULT_NONE;
    frame_length_next = frame_length;
    case (byte_position)
      POS_W'(1), POS_W'(2): if (item.rx_byte != START_ZERO) code = FAULT_START;
      POS_W'(3): if (item.rx_byte != START_FF) code = FAULT_START;
      POS_W'(4): begin
        frame_length_next = item.rx_byte;
        if (item.rx_byte < LEN_MIN) code = FAULT_LEN;
      end
      POS_W'(6): if (item.rx_byte != TFI_VALUE) code = FAULT_TFI;
      default: ;
    endcase
    if (!stored) begin
      code = FAULT_NONE;
      frame_length_next = frame_length;
    end

    fault_seen_next = fault_seen;
    if (code != FAULT_NONE && (fault_seen == FAULT_NONE || code < fault_seen))
      fault_seen_next = code;

    cap = (frame_length >= LEN_MIN) ? frame_length - LEN_MIN : 8'd0;
    if (cap > payload_limit) cap = payload_limit;

    emit = stored && byte_position >= HEADER_BYTES && fault_seen_next == FAULT_NONE
           && delivered_count < cap;
    delivered_count_next = emit ? delivered_count + 8'd1 : delivered_count;
    byte_position_next   = stored ? byte_position + POS_W'(1) : byte_position;

    final_fault = fault_seen_next;
    if (byte_position_next < HEADER_BYTES) final_fault = FAULT_SHORT;

    data_res = '{kind: KIND_DATA, payload_byte: item.rx_byte, payload_count: 8'd0,
                 fault: FAULT_NONE, last: 1'b0};
    if (final_fault != FAULT_NONE)
      final_res = '{kind: KIND_REJECT, payload_byte: 8'd0, payload_count: 8'd0,
                    fault: final_fault, last: 1'b1};
    else
      final_res = '{kind: KIND_DONE, payload_byte: 8'd0,
                    payload_count: delivered_count_next, fault: FAULT_NONE, last: 1'b1};

    push.n  = 2'd0;
    push.r0 = data_res;
    push.r1 = final_res;
    if (accept) begin
      if (emit && item.end_of_read) push.n = 2'd2;
      else if (emit) push.n = 2'd1;
      else if (item.end_of_read) begin
        push.n  = 2'd1;
        push.r0 = final_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      frame_length    <= '0;
      delivered_count <= '0;
      fault_seen      <= FAULT_NONE;
      payload_limit   <= LIMIT_RST;
    end else begin
      if (cfg_we) payload_limit <= cfg_data;
      if (accept) begin
        if (item.end_of_read) begin
          byte_position   <= '0;
          frame_length    <= '0;
          delivered_count <= '0;
          fault_seen      <= FAULT_NONE;
        end else begin
          byte_position   <= byte_position_next;
          frame_length    <= frame_length_next;
          delivered_count <= delivered_count_next;
          fault_seen      <= fault_seen_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/nrd_result_fifo.sv @@
// Result queue: four entries, up to two written and one read per cycle.
`default_nettype none
module nrd_result_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire nrd_pkg::push_t push,
  output logic                has_room,
  output logic                res_valid,
  input  wire logic           res_ready,
  output nrd_pkg::out_t       res
);
  import nrd_pkg::*;

  out_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign res_valid = count != 3'd0;
  assign res       = mem[rd_ptr];
  assign pop       = res_valid && res_ready;
  assign has_room  = count <= 3'd2;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.n == 2'd2) mem[wr_ptr + 2'd1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.n;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, push.n} - {2'b00, pop};
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/nfc_reader_response_deframer_top.sv @@
// Each result is registered into the result queue when the byte that causes it is accepted.
// Throughput: one byte per cycle; results drain one per cycle while res_ready is high,
// from a four-entry queue; item_ready is low while that queue holds more than two results.
// Reset (rst, synchronous): clears read state and queue, payload_limit returns to 255.
// Top level of the NFC reader response deframer.
`default_nettype none
module nfc_reader_response_deframer_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire nrd_pkg::in_t  item,
  output logic               res_valid,
  input  wire logic          res_ready,
  output nrd_pkg::out_t      res,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_data
);
  import nrd_pkg::*;

  push_t push;
  logic  has_room;

  assign item_ready = has_room;

  nrd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (item_valid && item_ready),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push)
  );

  nrd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .has_room  (has_room),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
`default_nettype wire
